/* hw/rtl/lru_tlb_top_assert.svh */
// Assertion macros shared by the translation buffer top level.
`ifndef LRU_TLB_TOP_ASSERT_SVH
`define LRU_TLB_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_tlb assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_tlb assertion failed");

`endif

/* hw/rtl/lru_tlb_pkg.sv */
// Package with sizes, rank update codes and the rank command type of the translation buffer.
`timescale 1ns / 1ps
package lru_tlb_pkg;

	localparam int ENTRIES    = 16;
	localparam int PAGE_BITS  = 16;
	localparam int FRAME_BITS = 16;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int CAP_W      = 5;
	localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Rank update operations issued by the sequencer.
	localparam logic [1:0] RK_NONE    = 2'd0;
	localparam logic [1:0] RK_PROMOTE = 2'd1;
	localparam logic [1:0] RK_FILL    = 2'd2;
	localparam logic [1:0] RK_DROP    = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] slot;
		logic [IDX_W-1:0] ref_age;
		logic             evict;
		logic [IDX_W-1:0] old_slot;
	} rank_cmd_t;

endpackage

/* hw/rtl/lru_tlb_rank.sv */
// Valid bits, recency ranks and fill count of the translation buffer entries.
`timescale 1ns / 1ps
module lru_tlb_rank (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lru_tlb_pkg::rank_cmd_t            cmd,
	input  logic [lru_tlb_pkg::IDX_W-1:0]     rd_idx,
	output logic [lru_tlb_pkg::ENTRIES-1:0]   valid_vec,
	output logic [lru_tlb_pkg::IDX_W-1:0]     age_rd,
	output logic [lru_tlb_pkg::CNT_W-1:0]     used
);

	localparam int CNT_W = lru_tlb_pkg::CNT_W;

	logic [lru_tlb_pkg::ENTRIES-1:0] valid_q;
	logic [lru_tlb_pkg::IDX_W-1:0]   age_q [lru_tlb_pkg::ENTRIES];
	logic [lru_tlb_pkg::CNT_W-1:0]   used_q;

	assign valid_vec = valid_q;
	assign age_rd    = age_q[rd_idx];
	assign used      = used_q;

	// Valid bits change on fill and drop; the fill count changes on a drop and on a fill without eviction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else begin
			unique case (cmd.op)
				lru_tlb_pkg::RK_FILL: begin
					if (cmd.evict) begin
						valid_q[cmd.old_slot] <= 1'b0;
					end
					valid_q[cmd.slot] <= 1'b1;
					if (!cmd.evict) begin
						used_q <= used_q + CNT_W'(1);
					end
				end
				lru_tlb_pkg::RK_DROP: begin
					valid_q[cmd.slot] <= 1'b0;
					used_q            <= used_q - CNT_W'(1);
				end
				lru_tlb_pkg::RK_NONE,
				lru_tlb_pkg::RK_PROMOTE: begin
				end
			endcase
		end
	end

	// Every entry adjusts its own rank in parallel; promote and drop compare it against the reference rank.
	always_ff @(posedge clk) begin
		for (int i = 0; i < lru_tlb_pkg::ENTRIES; i++) begin
			unique case (cmd.op)
				lru_tlb_pkg::RK_PROMOTE: begin
					if (cmd.slot == lru_tlb_pkg::IDX_W'(i)) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && age_q[i] < cmd.ref_age) begin
						age_q[i] <= age_q[i] + lru_tlb_pkg::IDX_W'(1);
					end
				end
				lru_tlb_pkg::RK_FILL: begin
					if (cmd.slot == lru_tlb_pkg::IDX_W'(i)) begin
						age_q[i] <= '0;
					end else if (valid_q[i] &&
						!(cmd.evict && cmd.old_slot == lru_tlb_pkg::IDX_W'(i))) begin
						age_q[i] <= age_q[i] + lru_tlb_pkg::IDX_W'(1);
					end
				end
				lru_tlb_pkg::RK_DROP: begin
					if (valid_q[i] && age_q[i] > cmd.ref_age) begin
						age_q[i] <= age_q[i] - lru_tlb_pkg::IDX_W'(1);
					end
				end
				lru_tlb_pkg::RK_NONE: begin
				end
			endcase
		end
	end

endmodule

/* hw/rtl/lru_tlb_top.sv */
// Top level of the fully associative translation buffer with LRU replacement.
//
//  Channel  Direction  Handshake               Payload
//  req      in         req_valid / req_stall   func, page_number, frame_number
//  rsp      out        rsp_valid / rsp_stall   hit, frame_out, evicted, evicted_page, removed
//  cfg      in         cfg_valid / cfg_ready   capacity
//
// An item is accepted, then a single comparator walks all 16 entries of the tag
// store in turn, and then the rank update and the result load are done together.
// The update cycle waits while the previous result is still held by a stalled sink.
// Reset clears all valid bits and the fill count and sets capacity to 16; no clearing pass.
// Configuration writes are taken only while no item is in flight.
`timescale 1ns / 1ps
`include "lru_tlb_top_assert.svh"
module lru_tlb_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 func,
	input  logic [lru_tlb_pkg::PAGE_BITS-1:0]    page_number,
	input  logic [lru_tlb_pkg::FRAME_BITS-1:0]   frame_number,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic                                 hit,
	output logic [lru_tlb_pkg::FRAME_BITS-1:0]   frame_out,
	output logic                                 evicted,
	output logic [lru_tlb_pkg::PAGE_BITS-1:0]    evicted_page,
	output logic                                 removed,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lru_tlb_pkg::CAP_W-1:0]        capacity
);

	localparam int IDX_W = lru_tlb_pkg::IDX_W;
	localparam int CNT_W = lru_tlb_pkg::CNT_W;
	localparam int CMP_W = lru_tlb_pkg::CMP_W;
	localparam int KEY_W = (lru_tlb_pkg::PAGE_BITS > lru_tlb_pkg::FRAME_BITS) ?
		lru_tlb_pkg::PAGE_BITS : lru_tlb_pkg::FRAME_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                          state_q;
	logic [IDX_W-1:0]                    walk_q;
	logic [lru_tlb_pkg::CAP_W-1:0]       cap_q;

	// Item held for the duration of the walk.
	logic                                func_q;
	logic [lru_tlb_pkg::PAGE_BITS-1:0]   page_in_q;
	logic [lru_tlb_pkg::FRAME_BITS-1:0]  frame_in_q;

	// Tag and data store, written at the fill slot and read at the walk index.
	logic [lru_tlb_pkg::PAGE_BITS-1:0]   page_arr_q  [lru_tlb_pkg::ENTRIES];
	logic [lru_tlb_pkg::FRAME_BITS-1:0]  frame_arr_q [lru_tlb_pkg::ENTRIES];

	// Results gathered during the walk.
	logic                                match_found_q;
	logic [IDX_W-1:0]                    match_idx_q;
	logic [IDX_W-1:0]                    match_age_q;
	logic [lru_tlb_pkg::FRAME_BITS-1:0]  match_frame_q;
	logic                                old_found_q;
	logic [IDX_W-1:0]                    old_idx_q;
	logic [lru_tlb_pkg::PAGE_BITS-1:0]   old_page_q;
	logic                                free_found_q;
	logic [IDX_W-1:0]                    free_idx_q;

	// Output register.
	logic                                rsp_valid_q;
	logic                                hit_q;
	logic [lru_tlb_pkg::FRAME_BITS-1:0]  frame_out_q;
	logic                                evicted_q;
	logic [lru_tlb_pkg::PAGE_BITS-1:0]   evicted_page_q;
	logic                                removed_q;

	lru_tlb_pkg::rank_cmd_t              cmd;
	logic [lru_tlb_pkg::ENTRIES-1:0]     valid_vec;
	logic [IDX_W-1:0]                    age_rd;
	logic [CNT_W-1:0]                    used;

	logic                                cur_valid;
	logic [KEY_W-1:0]                    cmp_a;
	logic [KEY_W-1:0]                    cmp_b;
	logic                                cmp_eq;
	logic                                is_oldest;
	logic [CMP_W-1:0]                    cap_ext;
	logic [CMP_W-1:0]                    eff_cap;
	logic                                need_evict;
	logic [IDX_W-1:0]                    fill_slot;
	logic                                out_free;
	logic                                upd_go;
	logic                                walk_last;

	lru_tlb_rank u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_idx    (walk_q),
		.valid_vec (valid_vec),
		.age_rd    (age_rd),
		.used      (used)
	);

	assign req_stall    = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign frame_out    = frame_out_q;
	assign evicted      = evicted_q;
	assign evicted_page = evicted_page_q;
	assign removed      = removed_q;

	// The shared comparator checks the stored page or frame of the walked entry.
	always_comb begin
		cur_valid = valid_vec[walk_q];
		if (func_q) begin
			cmp_a = KEY_W'(frame_arr_q[walk_q]);
			cmp_b = KEY_W'(frame_in_q);
		end else begin
			cmp_a = KEY_W'(page_arr_q[walk_q]);
			cmp_b = KEY_W'(page_in_q);
		end
		cmp_eq    = (cmp_a == cmp_b);
		is_oldest = cur_valid && (CNT_W'(age_rd) == used - CNT_W'(1));
		walk_last = (walk_q == IDX_W'(lru_tlb_pkg::ENTRIES - 1));
	end

	// Capacity is clamped to the range one to the number of entries.
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(lru_tlb_pkg::ENTRIES)) begin
			eff_cap = CMP_W'(lru_tlb_pkg::ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		need_evict = (CMP_W'(used) >= eff_cap) && old_found_q;
		if (need_evict && !(free_found_q && free_idx_q < old_idx_q)) begin
			fill_slot = old_idx_q;
		end else begin
			fill_slot = free_idx_q;
		end
	end

	// The update runs once the output register can take the result.
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign upd_go   = (state_q == ST_UPD) && out_free;

	always_comb begin
		cmd          = '0;
		cmd.op       = lru_tlb_pkg::RK_NONE;
		cmd.slot     = match_idx_q;
		cmd.ref_age  = match_age_q;
		cmd.evict    = need_evict;
		cmd.old_slot = old_idx_q;
		if (upd_go) begin
			priority if (!func_q && match_found_q) begin
				cmd.op = lru_tlb_pkg::RK_PROMOTE;
			end else if (!func_q) begin
				cmd.op   = lru_tlb_pkg::RK_FILL;
				cmd.slot = fill_slot;
			end else if (match_found_q) begin
				cmd.op = lru_tlb_pkg::RK_DROP;
			end else begin
				cmd.op = lru_tlb_pkg::RK_NONE;
			end
		end
	end

	// Sequencer and walk bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			walk_q        <= '0;
			cap_q         <= lru_tlb_pkg::CAP_RESET;
			match_found_q <= 1'b0;
			old_found_q   <= 1'b0;
			free_found_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity;
			end
			// A new result loads the output register; otherwise an accepted beat empties it.
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q       <= ST_WALK;
						walk_q        <= '0;
						match_found_q <= 1'b0;
						old_found_q   <= 1'b0;
						free_found_q  <= 1'b0;
					end
				end
				ST_WALK: begin
					if (cur_valid && cmp_eq &&
						(!match_found_q || (func_q && age_rd > match_age_q))) begin
						match_found_q <= 1'b1;
					end
					if (is_oldest) begin
						old_found_q <= 1'b1;
					end
					if (!cur_valid) begin
						free_found_q <= 1'b1;
					end
					walk_q <= walk_q + IDX_W'(1);
					if (walk_last) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: captured item, walk findings, store writes and result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			func_q     <= func;
			page_in_q  <= page_number;
			frame_in_q <= frame_number;
		end
		if (state_q == ST_WALK) begin
			if (cur_valid && cmp_eq &&
				(!match_found_q || (func_q && age_rd > match_age_q))) begin
				match_idx_q   <= walk_q;
				match_age_q   <= age_rd;
				match_frame_q <= frame_arr_q[walk_q];
			end
			if (is_oldest) begin
				old_idx_q  <= walk_q;
				old_page_q <= page_arr_q[walk_q];
			end
			if (!cur_valid && !free_found_q) begin
				free_idx_q <= walk_q;
			end
		end
		if (cmd.op == lru_tlb_pkg::RK_FILL) begin
			page_arr_q[fill_slot]  <= page_in_q;
			frame_arr_q[fill_slot] <= frame_in_q;
		end
		if (upd_go) begin
			hit_q          <= !func_q && match_found_q;
			removed_q      <= func_q && match_found_q;
			evicted_q      <= !func_q && !match_found_q && need_evict;
			if (func_q) begin
				frame_out_q <= '0;
			end else if (match_found_q) begin
				frame_out_q <= match_frame_q;
			end else begin
				frame_out_q <= frame_in_q;
			end
			if (!func_q && !match_found_q && need_evict) begin
				evicted_page_q <= old_page_q;
			end else begin
				evicted_page_q <= '0;
			end
		end
	end

	// Consistency checks on the rank store and the result register.
	`LT_ASSERT_IMPL(a_used_count, 1'b1, used == CNT_W'($countones(valid_vec)))
	`LT_ASSERT_IMPL(a_used_bound, 1'b1, CMP_W'(used) <= CMP_W'(lru_tlb_pkg::ENTRIES))
	`LT_ASSERT_IMPL(a_rsp_source, $rose(rsp_valid_q), $past(state_q) == ST_UPD)
	`LT_ASSERT_IMPL(a_rsp_exclusive, rsp_valid_q, !(hit_q && evicted_q) && !(removed_q && (hit_q || evicted_q)))

endmodule

/* dv/lru_tlb_top_tb.sv */
// Self-checking testbench for the LRU translation buffer top level.
`timescale 1ns / 1ps
module testbench;
	import lru_tlb_pkg::*;

	// Item codes on the func field.
	localparam logic FN_LOOKUP = 1'b0;
	localparam logic FN_INVAL  = 1'b1;

	localparam int QUIET_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 182;

	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_CLOGGED} sink_mode_e;

	typedef struct packed {
		logic                  func;
		logic [PAGE_BITS-1:0]  page;
		logic [FRAME_BITS-1:0] frame;
	} xlat_req_t;

	typedef struct packed {
		logic                  hit;
		logic [FRAME_BITS-1:0] frame;
		logic                  evicted;
		logic [PAGE_BITS-1:0]  ev_page;
		logic                  removed;
	} xlat_rsp_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  req_valid    = 1'b0;
	logic                  req_stall;
	logic                  func         = FN_LOOKUP;
	logic [PAGE_BITS-1:0]  page_number  = '0;
	logic [FRAME_BITS-1:0] frame_number = '0;
	logic                  rsp_valid;
	logic                  rsp_stall    = 1'b0;
	logic                  hit;
	logic [FRAME_BITS-1:0] frame_out;
	logic                  evicted;
	logic [PAGE_BITS-1:0]  evicted_page;
	logic                  removed;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CAP_W-1:0]      capacity     = CAP_RESET;

	// Shadow copy of the buffer contents and recency ranks.
	bit                    tlb_valid[ENTRIES];
	logic [PAGE_BITS-1:0]  tlb_page[ENTRIES];
	logic [FRAME_BITS-1:0] tlb_frame[ENTRIES];
	int                    tlb_rank[ENTRIES];
	int                    tlb_used = 0;
	logic [CAP_W-1:0]      tlb_cap  = CAP_RESET;

	xlat_req_t req_backlog[$];
	xlat_rsp_t xlat_due[$];
	int        backlog_open = 0;

	logic       req_taken  = 1'b0;
	xlat_req_t  next_req;
	int         burst_left = 1;
	int         gap_left   = 0;
	sink_mode_e sink_mode  = SINK_OPEN;
	int         sink_left  = 0;
	int         sink_tick  = 0;
	int         quiet_cycles = 0;

	int n_req = 0, n_hit = 0, n_evict = 0, n_removed = 0, n_cfg = 0;
	int n_errors = 0;
	int caps[RANDOM_PHASES];

	lru_tlb_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.page_number  (page_number),
		.frame_number (frame_number),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.hit          (hit),
		.frame_out    (frame_out),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.removed      (removed),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.capacity     (capacity)
	);

	always #2 clk = ~clk;

	// Remove one entry; every entry older than it moves one rank closer to recent.
	function automatic void drop_entry(input int s);
		int i;
		tlb_valid[s] = 1'b0;
		for (i = 0; i < ENTRIES; i++)
			if (tlb_valid[i] && tlb_rank[i] > tlb_rank[s])
				tlb_rank[i]--;
		if (tlb_used > 0)
			tlb_used--;
	endfunction

	// Work out the result of one request and update the shadow buffer.
	function automatic xlat_rsp_t predict_translation(input xlat_req_t r);
		xlat_rsp_t o;
		int        i, s, old, lim;
		o = '0;
		s = -1;
		if (r.func == FN_LOOKUP) begin
			for (i = 0; i < ENTRIES; i++)
				if (s < 0 && tlb_valid[i] && tlb_page[i] == r.page)
					s = i;
			if (s >= 0) begin
				// Hit: the entry becomes most recent.
				o.hit   = 1'b1;
				o.frame = tlb_frame[s];
				for (i = 0; i < ENTRIES; i++)
					if (tlb_valid[i] && tlb_rank[i] < tlb_rank[s])
						tlb_rank[i]++;
				tlb_rank[s] = 0;
			end else begin
				lim = (tlb_cap == 0) ? 1 : (int'(tlb_cap) > ENTRIES) ? ENTRIES : int'(tlb_cap);
				if (tlb_used >= lim) begin
					old = -1;
					for (i = 0; i < ENTRIES; i++)
						if (tlb_valid[i] && (old < 0 || tlb_rank[i] > tlb_rank[old]))
							old = i;
					if (old >= 0) begin
						o.evicted = 1'b1;
						o.ev_page = tlb_page[old];
						drop_entry(old);
					end
				end
				for (i = 0; i < ENTRIES; i++)
					if (s < 0 && !tlb_valid[i])
						s = i;
				if (s >= 0) begin
					for (i = 0; i < ENTRIES; i++)
						if (tlb_valid[i])
							tlb_rank[i]++;
					tlb_valid[s] = 1'b1;
					tlb_page[s]  = r.page;
					tlb_frame[s] = r.frame;
					tlb_rank[s]  = 0;
					tlb_used++;
				end
				o.frame = r.frame;
			end
		end else begin
			// Invalidate the least recent entry that maps the frame.
			for (i = 0; i < ENTRIES; i++)
				if (tlb_valid[i] && tlb_frame[i] == r.frame &&
						(s < 0 || tlb_rank[i] > tlb_rank[s]))
					s = i;
			if (s >= 0) begin
				drop_entry(s);
				o.removed = 1'b1;
			end
		end
		return o;
	endfunction

	task automatic queue_req(input logic f, input logic [PAGE_BITS-1:0] p,
			input logic [FRAME_BITS-1:0] fr);
		req_backlog.push_back('{func: f, page: p, frame: fr});
		backlog_open++;
	endtask

	// Block until every queued request is accepted and every result is back.
	task automatic wait_drained();
		do @(negedge clk);
		while (backlog_open != 0 || xlat_due.size() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		capacity  <= v;
		do @(posedge clk);
		while (!cfg_ready);
		tlb_cap = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic over small page and frame pools so that hits, evictions
	// and shared frames happen often; a tenth of the values are fully random.
	task automatic queue_random(input int n);
		logic [PAGE_BITS-1:0]  page_pool[20];
		logic [FRAME_BITS-1:0] frame_pool[12];
		int np, nf, lim, i;
		logic f;
		logic [PAGE_BITS-1:0]  p;
		logic [FRAME_BITS-1:0] fr;
		lim = (tlb_cap == 0) ? 1 : (int'(tlb_cap) > ENTRIES) ? ENTRIES : int'(tlb_cap);
		np  = lim + $urandom_range(1, 4);
		if (np > 20)
			np = 20;
		nf = $urandom_range(3, 12);
		for (i = 0; i < 20; i++)
			page_pool[i] = PAGE_BITS'($urandom);
		for (i = 0; i < 12; i++)
			frame_pool[i] = FRAME_BITS'($urandom);
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				page_pool[$urandom_range(0, np - 1)] = PAGE_BITS'($urandom);
			f  = ($urandom_range(0, 4) == 0) ? FN_INVAL : FN_LOOKUP;
			p  = ($urandom_range(0, 9) == 0) ? PAGE_BITS'($urandom)
				: page_pool[$urandom_range(0, np - 1)];
			fr = ($urandom_range(0, 9) == 0) ? FRAME_BITS'($urandom)
				: frame_pool[$urandom_range(0, nf - 1)];
			queue_req(f, p, fr);
		end
	endtask

	// Request driver: bursts of beats separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (gap_left != 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				next_req = req_backlog.pop_front();
				func         <= next_req.func;
				page_number  <= next_req.page;
				frame_number <= next_req.frame;
				req_valid    <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result sink stall pattern: switches between open, coin flip, periodic and clogged.
	always @(negedge clk) begin
		sink_tick <= sink_tick + 1;
		if (sink_left == 0) begin
			sink_mode <= sink_mode_e'($urandom_range(0, 3));
			sink_left <= $urandom_range(16, 160);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			SINK_OPEN:     rsp_stall <= 1'b0;
			SINK_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
			SINK_PERIODIC: rsp_stall <= (sink_tick % 5) < 2;
			default:       rsp_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Request monitor: predict the result of every accepted beat.
	always @(posedge clk) begin
		xlat_rsp_t want;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			want = predict_translation('{func: func, page: page_number, frame: frame_number});
			xlat_due.push_back(want);
			backlog_open--;
			n_req++;
			n_hit     += want.hit;
			n_evict   += want.evicted;
			n_removed += want.removed;
		end
	end

	// Result monitor: compare each accepted beat with the oldest prediction.
	always @(posedge clk) begin
		xlat_rsp_t got, want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = '{hit: hit, frame: frame_out, evicted: evicted, ev_page: evicted_page,
				removed: removed};
			if (xlat_due.size() == 0) begin
				if (n_errors < 10)
					$display("%0t: result beat with nothing outstanding: hit %0b frame %h",
						$realtime, got.hit, got.frame);
				n_errors++;
			end else begin
				want = xlat_due.pop_front();
				if (got.hit !== want.hit || got.frame !== want.frame ||
						got.evicted !== want.evicted || got.ev_page !== want.ev_page ||
						got.removed !== want.removed) begin
					if (n_errors < 10)
						$display({"%0t: mismatch (expected/actual) hit %0b/%0b frame %h/%h ",
							"evicted %0b/%0b evicted_page %h/%h removed %0b/%0b"}, $realtime,
							want.hit, got.hit, want.frame, got.frame, want.evicted,
							got.evicted, want.ev_page, got.ev_page, want.removed, got.removed);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, xlat_due.size());
			$display("lru_tlb_top verification failed");
			$finish;
		end
	end

	// Sequence: reset, directed phases, then random phases at several capacities.
	initial begin
		int k;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill, hit, shared frames, invalidate with and without a match,
		// hit on the least recent entry and field extremes.
		write_capacity(5'd16);
		queue_req(FN_LOOKUP, 16'h0000, 16'h0000);
		queue_req(FN_LOOKUP, 16'hFFFF, 16'hFFFF);
		queue_req(FN_LOOKUP, 16'h0000, 16'hAAAA);
		queue_req(FN_LOOKUP, 16'h0001, 16'hFFFF);
		queue_req(FN_INVAL,  16'h1234, 16'hFFFF);
		queue_req(FN_INVAL,  16'h0000, 16'hBEEF);
		queue_req(FN_LOOKUP, 16'h0002, 16'h0002);
		queue_req(FN_LOOKUP, 16'h0000, 16'h0007);
		queue_req(FN_INVAL,  16'hFFFF, 16'h0000);
		queue_req(FN_LOOKUP, 16'h0003, 16'h0003);
		queue_req(FN_LOOKUP, 16'h0004, 16'h0004);
		wait_drained();

		// Capacity lowered under the current fill: misses evict one and refill.
		write_capacity(5'd2);
		queue_req(FN_LOOKUP, 16'h0005, 16'h0005);
		queue_req(FN_LOOKUP, 16'h0002, 16'h0009);
		queue_req(FN_LOOKUP, 16'h0006, 16'h0006);
		wait_drained();

		// Zero capacity behaves as one.
		write_capacity(5'd0);
		queue_req(FN_LOOKUP, 16'h0007, 16'h0007);
		queue_req(FN_INVAL,  16'h0000, 16'h0004);
		queue_req(FN_INVAL,  16'h0000, 16'h0002);
		queue_req(FN_LOOKUP, 16'h0008, 16'h0008);
		queue_req(FN_LOOKUP, 16'h0008, 16'h0001);
		wait_drained();

		caps = '{5'd31, 5'd1, 5'd16, 5'd5, 5'd17, 5'd0, 5'd2, 5'd9};
		caps[6] = $urandom_range(2, 15);
		for (k = 0; k < RANDOM_PHASES; k++) begin
			write_capacity(CAP_W'(caps[k]));
			queue_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (xlat_due.size() != 0) begin
			$display("%0d predicted results never arrived", xlat_due.size());
			n_errors += xlat_due.size();
		end
		$display("Covered %0d requests under %0d capacity writes:", n_req, n_cfg);
		$display("%0d hits, %0d evictions, %0d removals.", n_hit, n_evict, n_removed);
		$display("Errors: %0d", n_errors);
		if (n_errors == 0)
			$display("lru_tlb_top verification clean");
		else
			$display("lru_tlb_top verification failed");
		$finish;
	end

endmodule
